/* rtl/sctc_pkg.sv */
// ----------------------------------------------------------------------------
// sctc_pkg
// Shared types and constants of the sparse CSR to CSC transpose unit.
// ----------------------------------------------------------------------------
package sctc_pkg;

    localparam int DEF_MAX_DIM = 1024;
    localparam int DEF_MAX_NZ  = 4096;

    localparam int ROW_W   = 10;
    localparam int VAL_W   = 64;
    localparam int DIM_W   = 11;
    localparam int PTR_W   = 13;
    localparam int KIND_W  = 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [KIND_W-1:0] KIND_PTR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLR,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_PFX_RD,
        ST_PFX_WR,
        ST_SCT_RD,
        ST_SCT_PTR,
        ST_SCT_WR,
        ST_PTR_RD,
        ST_PTR_FIX,
        ST_READY,
        ST_FETCH_RD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                 cmd;
        logic [ROW_W-1:0]     row;
        logic [ROW_W-1:0]     col;
        logic [VAL_W-1:0]     value;
        logic                 last;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [PTR_W-1:0]     pointer;
        logic [ROW_W-1:0]     entry_row;
        logic [VAL_W-1:0]     entry_value;
        logic                 final_res;
        logic                 overflow;
    } rsp_t;

endpackage

/* rtl/sctc_req_if.sv */
// ----------------------------------------------------------------------------
// sctc_req_if
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface sctc_req_if
    import sctc_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sctc_rsp_if.sv */
// ----------------------------------------------------------------------------
// sctc_rsp_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface sctc_rsp_if
    import sctc_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sparse_csr_to_csc_transpose_unit.sv */
// ----------------------------------------------------------------------------
// sparse_csr_to_csc_transpose_unit
// Loads a sparse matrix in row order and returns it in compressed-column form.
// ----------------------------------------------------------------------------
// A fetch goes through a memory read, then the output register, and then
// waits at the output until the result is taken. The load with last set
// starts the build, during which no request is taken: a clear pass over all
// MAX_DIM+1 pointer-memory entries, a count pass over the stored entries
// (read-modify-write of the count), a prefix pass over the columns, a scatter
// pass over the stored entries (entry read, pointer read, write) and a pointer
// restore over the columns.
module sparse_csr_to_csc_transpose_unit
    import sctc_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int MAX_NZ  = DEF_MAX_NZ
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [DIM_W-1:0] cfg_wdata,
    sctc_req_if.sink         req,
    sctc_rsp_if.source       rsp
);
    localparam int NZ_AW  = (MAX_NZ > 1) ? $clog2(MAX_NZ) : 1;
    localparam int CNT_W  = $clog2(MAX_NZ + 1);
    localparam int PD_W   = $clog2(MAX_DIM + 2);
    localparam int PA_W   = $clog2(MAX_DIM + 1) > 0 ? $clog2(MAX_DIM + 1) : 1;
    localparam int CUR_W  = $clog2(MAX_DIM + MAX_NZ + 2);

    // memories
    logic [ROW_W-1:0] ld_row_mem [MAX_NZ];
    logic [ROW_W-1:0] ld_col_mem [MAX_NZ];
    logic [VAL_W-1:0] ld_val_mem [MAX_NZ];
    logic [ROW_W-1:0] out_row_mem [MAX_NZ];
    logic [VAL_W-1:0] out_val_mem [MAX_NZ];
    logic [PTR_W-1:0] ptr_mem [MAX_DIM+1];

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] dim_reg;
    logic [PD_W-1:0]  bdim_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [PD_W-1:0]  pidx_reg;
    logic [PTR_W-1:0] sum_reg;
    logic [PTR_W-1:0] kept_reg;
    logic [CUR_W-1:0] cur_reg;
    logic             ovf_reg;
    logic             built_reg;
    logic             out_valid_reg;
    rsp_t             out_reg;

    logic [ROW_W-1:0] rd_row_q, rd_col_q;
    logic [VAL_W-1:0] rd_val_q;
    logic [PTR_W-1:0] rd_ptr_q;
    logic [ROW_W-1:0] ord_q;
    logic [VAL_W-1:0] oval_q;

    logic             acc;
    logic [PD_W-1:0]  eff_dim;
    logic             in_range;
    logic [CUR_W-1:0] n_ptr, total;
    logic             fetch_is_ptr, fetch_is_ent;

    assign acc = req.valid && req.ready;
    assign req.ready = (state_reg == ST_LOAD || state_reg == ST_READY) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        if (dim_reg == '0)
            eff_dim = PD_W'(1);
        else if ({21'd0, dim_reg} > 32'(MAX_DIM))
            eff_dim = PD_W'(MAX_DIM);
        else
            eff_dim = PD_W'(dim_reg);
    end

    assign in_range = (PD_W'(rd_col_q) < bdim_reg) && (PD_W'(rd_row_q) < bdim_reg);
    assign n_ptr = CUR_W'(bdim_reg) + CUR_W'(1);
    assign total = n_ptr + CUR_W'(kept_reg);
    assign fetch_is_ptr = cur_reg < n_ptr;
    assign fetch_is_ent = !fetch_is_ptr && (cur_reg < total);

    // load store: written at load time, read during count and scatter
    logic ld_we;
    assign ld_we = acc && req.data.cmd == CMD_LOAD && (built_reg ? 1'b1 : count_reg < CNT_W'(MAX_NZ));

    logic [NZ_AW-1:0] ld_waddr;
    assign ld_waddr = built_reg ? '0 : NZ_AW'(count_reg);

    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            ld_row_mem[ld_waddr] <= req.data.row;
            ld_col_mem[ld_waddr] <= req.data.col;
            ld_val_mem[ld_waddr] <= req.data.value;
        end
        rd_row_q <= ld_row_mem[NZ_AW'(idx_reg)];
        rd_col_q <= ld_col_mem[NZ_AW'(idx_reg)];
        rd_val_q <= ld_val_mem[NZ_AW'(idx_reg)];
    end

    // pointer memory port
    logic             p_we;
    logic [PA_W-1:0]  p_waddr, p_raddr;
    logic [PTR_W-1:0] p_wdata;

    always_ff @(posedge clk)
    begin
        if (p_we)
            ptr_mem[p_waddr] <= p_wdata;
        rd_ptr_q <= ptr_mem[p_raddr];
    end

    // output store
    logic             o_we;
    logic [NZ_AW-1:0] o_waddr, o_raddr;

    always_ff @(posedge clk)
    begin
        if (o_we)
        begin
            out_row_mem[o_waddr] <= rd_row_q;
            out_val_mem[o_waddr] <= rd_val_q;
        end
        ord_q  <= out_row_mem[o_raddr];
        oval_q <= out_val_mem[o_raddr];
    end

    logic [CUR_W-1:0] ent_k;
    assign ent_k = cur_reg - n_ptr;
    assign o_raddr = NZ_AW'(ent_k);
    assign o_waddr = NZ_AW'(rd_ptr_q);
    assign o_we = (state_reg == ST_SCT_WR) && in_range && ({19'd0, rd_ptr_q} < 32'(MAX_NZ));

    // pointer port control
    always_comb
    begin
        p_we    = 1'b0;
        p_waddr = PA_W'(pidx_reg);
        p_wdata = '0;
        p_raddr = PA_W'(pidx_reg);
        unique case (state_reg)
            ST_CLR:
            begin
                p_we = 1'b1;
            end
            ST_CNT_RD, ST_SCT_RD:
            begin
                p_raddr = PA_W'(rd_col_q);
            end
            ST_CNT_WR:
            begin
                p_we    = in_range;
                p_waddr = PA_W'(rd_col_q);
                p_wdata = rd_ptr_q + PTR_W'(1);
                p_raddr = PA_W'(rd_col_q);
            end
            ST_PFX_WR:
            begin
                p_we    = 1'b1;
                p_wdata = (pidx_reg == bdim_reg) ? sum_reg : sum_reg;
            end
            ST_SCT_PTR:
            begin
                p_raddr = PA_W'(rd_col_q);
            end
            ST_SCT_WR:
            begin
                p_we    = in_range;
                p_waddr = PA_W'(rd_col_q);
                p_wdata = rd_ptr_q + PTR_W'(1);
            end
            ST_PTR_RD:
            begin
                p_raddr = PA_W'(pidx_reg - PD_W'(1));
            end
            ST_PTR_FIX:
            begin
                // shift slot ends back to column starts: ptr[i] = end[i-1]
                p_we    = 1'b1;
                p_waddr = PA_W'(pidx_reg);
                p_wdata = (pidx_reg == '0) ? '0 : rd_ptr_q;
            end
            ST_FETCH_RD:
            begin
                p_raddr = PA_W'(cur_reg);
            end
            default:
            begin
                p_raddr = PA_W'(pidx_reg);
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD, ST_READY:
            begin
                if (acc && req.data.cmd == CMD_LOAD && req.data.last)
                    state_next = ST_CLR;
                else if (acc && req.data.cmd == CMD_LOAD)
                    state_next = ST_LOAD;
                else if (acc && state_reg == ST_READY && (fetch_is_ptr || fetch_is_ent))
                    state_next = ST_FETCH_RD;
            end
            ST_CLR:
                if (pidx_reg == PD_W'(MAX_DIM))
                    state_next = (count_reg == '0) ? ST_PFX_RD : ST_CNT_RD;
            ST_CNT_RD:   state_next = ST_CNT_WR;
            ST_CNT_WR:
                state_next = (idx_reg == count_reg) ? ST_PFX_RD : ST_CNT_RD;
            ST_PFX_RD:   state_next = ST_PFX_WR;
            ST_PFX_WR:
                if (pidx_reg == bdim_reg)
                    state_next = (count_reg == '0) ? ST_PTR_RD : ST_SCT_RD;
                else
                    state_next = ST_PFX_RD;
            ST_SCT_RD:   state_next = ST_SCT_PTR;
            ST_SCT_PTR:  state_next = ST_SCT_WR;
            ST_SCT_WR:
                state_next = (idx_reg == count_reg) ? ST_PTR_RD : ST_SCT_RD;
            ST_PTR_RD:   state_next = ST_PTR_FIX;
            ST_PTR_FIX:
                state_next = (pidx_reg == '0) ? ST_READY : ST_PTR_RD;
            ST_FETCH_RD: state_next = ST_OUT;
            ST_OUT:      state_next = ST_READY;
            default:     state_next = ST_LOAD;
        endcase
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            dim_reg       <= DIM_W'(1);
            bdim_reg      <= PD_W'(1);
            count_reg     <= '0;
            idx_reg       <= '0;
            pidx_reg      <= '0;
            sum_reg       <= '0;
            kept_reg      <= '0;
            cur_reg       <= '0;
            ovf_reg       <= 1'b0;
            built_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                dim_reg <= cfg_wdata;
            if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_LOAD, ST_READY:
                begin
                    if (acc && req.data.cmd == CMD_LOAD)
                    begin
                        built_reg <= 1'b0;
                        if (built_reg)
                        begin
                            count_reg <= CNT_W'(1);
                            ovf_reg   <= 1'b0;
                        end
                        else if (count_reg < CNT_W'(MAX_NZ))
                            count_reg <= count_reg + CNT_W'(1);
                        else
                            ovf_reg <= 1'b1;
                        if (req.data.last)
                        begin
                            bdim_reg <= eff_dim;
                            pidx_reg <= '0;
                            idx_reg  <= '0;
                        end
                    end
                    else if (acc)
                    begin
                        if (state_reg == ST_READY && (fetch_is_ptr || fetch_is_ent))
                        begin
                            // result built after the read
                        end
                        else
                        begin
                            out_valid_reg       <= 1'b1;
                            out_reg             <= '0;
                            out_reg.kind        <= KIND_NONE;
                            out_reg.overflow    <= ovf_reg;
                        end
                    end
                end
                ST_CLR:
                begin
                    if (pidx_reg == PD_W'(MAX_DIM))
                        pidx_reg <= '0;
                    else
                        pidx_reg <= pidx_reg + PD_W'(1);
                end
                ST_CNT_RD:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                ST_CNT_WR:
                begin
                    if (idx_reg == count_reg)
                        idx_reg <= '0;
                    sum_reg <= '0;
                end
                ST_PFX_RD:
                begin
                end
                ST_PFX_WR:
                begin
                    // ptr[i] <= running sum; add the count just read
                    if (pidx_reg == bdim_reg)
                    begin
                        kept_reg <= sum_reg;
                    end
                    else
                    begin
                        sum_reg  <= sum_reg + rd_ptr_q;
                        pidx_reg <= pidx_reg + PD_W'(1);
                    end
                end
                ST_SCT_RD:
                begin
                end
                ST_SCT_PTR:
                begin
                    // hold the entry until its slot is written
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                ST_SCT_WR:
                begin
                end
                ST_PTR_RD:
                begin
                end
                ST_PTR_FIX:
                begin
                    if (pidx_reg == '0)
                    begin
                        built_reg <= 1'b1;
                        cur_reg   <= '0;
                    end
                    else
                        pidx_reg <= pidx_reg - PD_W'(1);
                end
                ST_FETCH_RD:
                begin
                end
                ST_OUT:
                begin
                    out_valid_reg        <= 1'b1;
                    out_reg              <= '0;
                    out_reg.overflow     <= ovf_reg;
                    out_reg.final_res    <= (cur_reg + CUR_W'(1)) == total;
                    if (fetch_is_ptr)
                    begin
                        out_reg.kind    <= KIND_PTR;
                        out_reg.pointer <= rd_ptr_q;
                    end
                    else
                    begin
                        out_reg.kind <= KIND_ENTRY;
                        if ({{(32-CUR_W){1'b0}}, ent_k} < 32'(MAX_NZ))
                        begin
                            out_reg.entry_row   <= ord_q;
                            out_reg.entry_value <= oval_q;
                        end
                    end
                    cur_reg <= cur_reg + CUR_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the sparse CSR to CSC transpose unit. A directed table checks
// reset, the index extremes, dim clamping, out-of-range entries and column
// order. Random matrices of mixed order and density then follow, with
// truncated fetch runs, fetches during load and one store overflow. Each result is
// checked against a given table value or the behavioral model of the conversion kept here.
// ----------------------------------------------------------------------------
module tb_top;
    import sctc_pkg::*;

    localparam int NZ_CAP   = DEF_MAX_NZ;
    localparam int DIM_CAP  = DEF_MAX_DIM;
    localparam int STALL_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [DIM_W-1:0] cfg_wdata;

    sctc_req_if req ();
    sctc_rsp_if rsp ();

    sparse_csr_to_csc_transpose_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    // conversion model state
    logic [ROW_W-1:0] ld_row [NZ_CAP];
    logic [ROW_W-1:0] ld_col [NZ_CAP];
    logic [VAL_W-1:0] ld_val [NZ_CAP];
    int               col_ptr [DIM_CAP+1];
    int               slot_nxt [DIM_CAP+1];
    logic [ROW_W-1:0] csc_row [NZ_CAP];
    logic [VAL_W-1:0] csc_val [NZ_CAP];
    int               n_stored;
    int               fetch_pos;
    int               n_kept;
    int               built_dim;
    bit               converted;
    bit               dropped;
    logic [DIM_W-1:0] dim_reg;

    rsp_t pending_rsp [$];
    int   err_cnt;
    int   n_loads;
    int   n_fetches;
    int   n_checked;
    int   n_builds;
    int   n_ovf_seen;
    int   send_idle;
    int   recv_idle;
    int   recv_hold;

    typedef struct {
        bit               is_cfg;
        logic [DIM_W-1:0] cfg_val;
        req_t             r;
        bit               typed;
        rsp_t             exp_rsp;
    } dir_row_t;

    // ------------------------------------------------------------------
    // model of the block
    // ------------------------------------------------------------------
    function automatic void build_csc();
        int d;
        int sum;
        int c;
        d = (dim_reg == 0) ? 1 : ((dim_reg > DIM_CAP) ? DIM_CAP : int'(dim_reg));
        built_dim = d;
        sum = 0;
        for (int i = 0; i <= DIM_CAP; i++)
            col_ptr[i] = 0;
        for (int i = 0; i < n_stored; i++)
            if (ld_col[i] < d && ld_row[i] < d)
                col_ptr[ld_col[i]]++;
        for (int i = 0; i < d; i++)
        begin
            c = col_ptr[i];
            col_ptr[i] = sum;
            slot_nxt[i] = sum;
            sum += c;
        end
        col_ptr[d] = sum;
        n_kept = sum;
        for (int i = 0; i < n_stored; i++)
            if (ld_col[i] < d && ld_row[i] < d)
            begin
                c = slot_nxt[ld_col[i]];
                csc_row[c] = ld_row[i];
                csc_val[c] = ld_val[i];
                slot_nxt[ld_col[i]] = c + 1;
            end
        converted = 1'b1;
        fetch_pos = 0;
        n_builds++;
    endfunction

    function automatic bit convert_step(req_t r, output rsp_t o);
        int total;
        o = '0;
        if (r.cmd == CMD_LOAD)
        begin
            if (converted)
            begin
                converted = 1'b0;
                dropped = 1'b0;
                n_stored = 0;
                fetch_pos = 0;
            end
            if (n_stored < NZ_CAP)
            begin
                ld_row[n_stored] = r.row;
                ld_col[n_stored] = r.col;
                ld_val[n_stored] = r.value;
                n_stored++;
            end
            else
                dropped = 1'b1;
            if (r.last)
                build_csc();
            return 1'b0;
        end
        o.kind = KIND_NONE;
        o.overflow = dropped;
        if (converted)
        begin
            total = built_dim + 1 + n_kept;
            if (fetch_pos < built_dim + 1)
            begin
                o.kind = KIND_PTR;
                o.pointer = PTR_W'(col_ptr[fetch_pos]);
                o.final_res = (fetch_pos + 1 == total);
                fetch_pos++;
            end
            else if (fetch_pos < total)
            begin
                o.kind = KIND_ENTRY;
                o.entry_row = csc_row[fetch_pos - built_dim - 1];
                o.entry_value = csc_val[fetch_pos - built_dim - 1];
                o.final_res = (fetch_pos + 1 == total);
                fetch_pos++;
            end
        end
        return 1'b1;
    endfunction

    function automatic int fetches_left();
        if (!converted)
            return 0;
        return built_dim + 1 + n_kept - fetch_pos;
    endfunction

    function automatic rsp_t mk_rsp(logic [KIND_W-1:0] k, int p, logic [ROW_W-1:0] rw,
                                    logic [VAL_W-1:0] v, bit fin, bit ovf);
        rsp_t o;
        o.kind = k;
        o.pointer = PTR_W'(p);
        o.entry_row = rw;
        o.entry_value = v;
        o.final_res = fin;
        o.overflow = ovf;
        return o;
    endfunction

    function automatic req_t mk_load(int rw, int cl, logic [VAL_W-1:0] v, bit lst);
        req_t r;
        r.cmd = CMD_LOAD;
        r.row = ROW_W'(rw);
        r.col = ROW_W'(cl);
        r.value = v;
        r.last = lst;
        return r;
    endfunction

    function automatic req_t mk_fetch();
        req_t r;
        r = '0;
        r.cmd = CMD_FETCH;
        r.row = ROW_W'($urandom);
        r.col = ROW_W'($urandom);
        r.value = {$urandom, $urandom};
        r.last = 1'($urandom);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
        $display("ERROR %0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    task automatic send_req(req_t r, bit typed = 1'b0, rsp_t typed_rsp = '0);
        rsp_t o;
        bit has_rsp;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= r;
        do
            @(posedge clk);
        while (!req.ready);
        has_rsp = convert_step(r, o);
        if (r.cmd == CMD_LOAD)
            n_loads++;
        else
            n_fetches++;
        if (has_rsp)
            pending_rsp.push_back(typed ? typed_rsp : o);
    endtask

    // drop valid and hold until every expected result has come back
    task automatic drain();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_dim(logic [DIM_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        dim_reg = v;
    endtask

    // load one random matrix, then fetch some or all of its results
    task automatic run_matrix(logic [DIM_W-1:0] dv, int nz, int bad_pct);
        int d;
        int rw;
        int cl;
        int n;
        write_dim(dv);
        d = (dv == 0) ? 1 : ((dv > DIM_CAP) ? DIM_CAP : int'(dv));
        rw = 0;
        for (int i = 0; i < nz; i++)
        begin
            if ($urandom_range(99) < 4)
                send_req(mk_fetch());
            if ($urandom_range(99) < 35 && rw < d - 1)
                rw++;
            cl = $urandom_range(d - 1);
            if ($urandom_range(99) < bad_pct)
            begin
                if ($urandom_range(1))
                    cl = $urandom_range(1023);
                else
                    rw = $urandom_range(1023);
            end
            send_req(mk_load(rw, cl, {$urandom, $urandom}, i == nz - 1));
        end
        n = fetches_left();
        if ($urandom_range(99) < 10)
            n = $urandom_range(1, n);
        else
            n = n + $urandom_range(2);
        repeat (n)
            send_req(mk_fetch());
    endtask

    // ------------------------------------------------------------------
    // clock, result side, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold > 0)
            begin
                rsp.ready <= 1'b0;
                recv_hold--;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        rsp_t want;
        rsp_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                if (pending_rsp.size() == 0)
                begin
                    $display("ERROR %0t: result with none expected", $realtime);
                    err_cnt++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    n_checked++;
                    if (got.overflow === 1'b1)
                        n_ovf_seen++;
                    if (got.kind !== want.kind)
                        report_mismatch("kind", VAL_W'(got.kind), VAL_W'(want.kind));
                    if (got.pointer !== want.pointer)
                        report_mismatch("pointer", VAL_W'(got.pointer), VAL_W'(want.pointer));
                    if (got.entry_row !== want.entry_row)
                        report_mismatch("entry_row", VAL_W'(got.entry_row),
                                        VAL_W'(want.entry_row));
                    if (got.entry_value !== want.entry_value)
                        report_mismatch("entry_value", got.entry_value, want.entry_value);
                    if (got.final_res !== want.final_res)
                        report_mismatch("final_res", VAL_W'(got.final_res),
                                        VAL_W'(want.final_res));
                    if (got.overflow !== want.overflow)
                        report_mismatch("overflow", VAL_W'(got.overflow),
                                        VAL_W'(want.overflow));
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("ERROR: no request or result moved for %0d cycles", quiet);
                $display("** sparse_csr_to_csc_transpose_unit: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t dir_tbl [$];
        dir_row_t t;
        logic [VAL_W-1:0] ones;
        int idle_s [4];
        int idle_r [4];
        int m;
        int start_items;
        int dsel;
        logic [DIM_W-1:0] dv;

        idle_s = '{0, 76, 0, 20};
        idle_r = '{0, 0, 76, 20};
        ones = '1;
        err_cnt = 0; n_loads = 0; n_fetches = 0; n_checked = 0; n_builds = 0;
        n_ovf_seen = 0; send_idle = 0; recv_idle = 0; recv_hold = 0;
        n_stored = 0; fetch_pos = 0; n_kept = 0; built_dim = 1;
        converted = 1'b0; dropped = 1'b0; dim_reg = 1;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid <= 1'b0;
        req.data <= '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        t = '{default: '0};
        t.r = mk_fetch();
        t.typed = 1;
        t.exp_rsp = mk_rsp(KIND_NONE, 0, 0, 0, 0, 0);
        dir_tbl.push_back(t);
        t = '{default: '0};
        t.r = mk_load(0, 0, ones, 1);
        dir_tbl.push_back(t);
        t.r = mk_fetch(); t.typed = 1; t.exp_rsp = mk_rsp(KIND_PTR, 0, 0, 0, 0, 0);
        dir_tbl.push_back(t);
        t.r = mk_fetch(); t.exp_rsp = mk_rsp(KIND_PTR, 1, 0, 0, 0, 0);
        dir_tbl.push_back(t);
        t.r = mk_fetch(); t.exp_rsp = mk_rsp(KIND_ENTRY, 0, 0, ones, 1, 0);
        dir_tbl.push_back(t);
        t.r = mk_fetch(); t.exp_rsp = mk_rsp(KIND_NONE, 0, 0, 0, 0, 0);
        dir_tbl.push_back(t);
        // order above the maximum clamps to the maximum
        t = '{default: '0}; t.is_cfg = 1; t.cfg_val = '1;
        dir_tbl.push_back(t);
        t = '{default: '0};
        t.r = mk_load(1023, 1023, 64'h0, 0);
        dir_tbl.push_back(t);
        t.r = mk_load(1023, 0, 64'h5555_5555_5555_5555, 0);
        dir_tbl.push_back(t);
        t.r = mk_load(0, 1023, 64'hAAAA_AAAA_AAAA_AAAA, 1);
        dir_tbl.push_back(t);
        repeat (3)
        begin
            t.r = mk_fetch();
            dir_tbl.push_back(t);
        end
        // order zero acts as one; an out-of-range row is left out
        t = '{default: '0}; t.is_cfg = 1; t.cfg_val = 0;
        dir_tbl.push_back(t);
        t = '{default: '0};
        t.r = mk_load(5, 0, 64'h1234, 1);
        dir_tbl.push_back(t);
        t.r = mk_fetch(); t.typed = 1; t.exp_rsp = mk_rsp(KIND_PTR, 0, 0, 0, 0, 0);
        dir_tbl.push_back(t);
        t.r = mk_fetch(); t.exp_rsp = mk_rsp(KIND_PTR, 0, 0, 0, 1, 0);
        dir_tbl.push_back(t);
        t.r = mk_fetch(); t.exp_rsp = mk_rsp(KIND_NONE, 0, 0, 0, 0, 0);
        dir_tbl.push_back(t);
        // two entries in one column keep load order; rows go backward
        t = '{default: '0}; t.is_cfg = 1; t.cfg_val = 3;
        dir_tbl.push_back(t);
        t = '{default: '0};
        t.r = mk_load(2, 2, 64'h1, 0);
        dir_tbl.push_back(t);
        t.r = mk_load(0, 2, 64'h2, 0);
        dir_tbl.push_back(t);
        t.r = mk_load(1, 0, 64'h3, 1);
        dir_tbl.push_back(t);
        repeat (7)
        begin
            t.r = mk_fetch();
            dir_tbl.push_back(t);
        end

        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].is_cfg)
                write_dim(dir_tbl[i].cfg_val);
            else
                send_req(dir_tbl[i].r, dir_tbl[i].typed, dir_tbl[i].exp_rsp);
        end

        // random matrices across the idling phases
        start_items = n_loads + n_fetches;
        m = 0;
        while (n_loads + n_fetches - start_items < 900)
        begin
            send_idle = idle_s[m % 4];
            recv_idle = idle_r[m % 4];
            dsel = $urandom_range(99);
            if (dsel < 70)
                dv = $urandom_range(1, 16);
            else if (dsel < 94)
                dv = $urandom_range(17, 64);
            else if (dsel < 96)
                dv = 0;
            else if (dsel < 98)
                dv = DIM_CAP;
            else
                dv = '1;
            if (m == 5)
            begin
                // hold results back so the block fills and stalls its input
                drain();
                recv_hold = 400;
            end
            run_matrix(dv, $urandom_range(1, 40), 8);
            m++;
        end

        // fill the store past capacity; the dropped last load still closes it
        send_idle = 0;
        recv_idle = 0;
        write_dim(4);
        for (int i = 0; i < NZ_CAP + 4; i++)
            send_req(mk_load((i * 4) / (NZ_CAP + 4), $urandom_range(3), {$urandom, $urandom},
                             i == NZ_CAP + 3));
        repeat (8)
            send_req(mk_fetch());

        drain();
        repeat (50) @(posedge clk);
        $display("Covered %0d loads and %0d fetches over %0d built matrices,",
                 n_loads, n_fetches, n_builds);
        $display("%0d results checked, %0d of them flagging overflow.", n_checked, n_ovf_seen);
        if (err_cnt == 0)
            $display("** sparse_csr_to_csc_transpose_unit: PASSED **");
        else
            $display("** sparse_csr_to_csc_transpose_unit: FAILED **");
        $finish;
    end

endmodule
